FILE: src/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH       = 3'd0,
        CMD_POP        = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_GET        = 3'd4,
        CMD_PUT        = 3'd5,
        CMD_FIND       = 3'd6,
        CMD_REMOVE_VAL = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_PUSH,
        OP_WRITE_AT,
        OP_READ_AT,
        OP_POP,
        OP_RM_START,
        OP_INS_START,
        OP_CAPTURE,
        OP_SHIFT_R,
        OP_SHIFT_L,
        OP_FLUSH,
        OP_PLACE,
        OP_SCAN_START,
        OP_SCAN,
        OP_FOUND,
        OP_FOUND_RM,
        OP_ERR_EMPTY,
        OP_ERR_FULL,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_lt_used;
        logic idx_lt_cap;
        logic ptr_eq_idx;
        logic ptr_eq_used;
        logic clear_last;
        logic match;
        logic scan_miss;
    } t_flags;

endpackage

FILE: src/ils_datapath.sv
`timescale 1ns / 1ps

module ils_datapath #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ils_pkg::t_op   i_op,
    input  logic [3:0]     i_position_in,
    input  logic [31:0]    i_value_in,
    output ils_pkg::t_flags o_flags,
    output logic [31:0]    o_value_out,
    output logic [3:0]     o_position_out,
    output logic [1:0]     o_status,
    output logic [4:0]     o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    logic [WORD_BITS-1:0] r_mem [CAPACITY];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [CW-1:0]        r_used, n_used;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_tag, n_tag;
    logic [XW-1:0]        r_idx, n_idx;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [WORD_BITS-1:0] r_val, n_val;
    logic [3:0]           r_pos, n_pos;
    logic [1:0]           r_st, n_st;

    logic [31:0]          r_o_value;
    logic [3:0]           r_o_position;
    logic [1:0]           r_o_status;
    logic [4:0]           r_o_count;

    logic                 we, re;
    logic [AW-1:0]        waddr, raddr;
    logic [WORD_BITS-1:0] wdata;

    logic [XW-1:0]        used_x, ptr_x, idx_inc, tag_x;
    logic [CW-1:0]        used_m1, ptr_inc, ptr_dec, tag_inc;
    logic [63:0]          w_ext, val_ext;

    assign used_x  = XW'(r_used);
    assign ptr_x   = XW'(r_ptr);
    assign tag_x   = XW'(r_tag);
    assign idx_inc = r_idx + XW'(1);
    assign used_m1 = r_used - CW'(1);
    assign ptr_inc = r_ptr + CW'(1);
    assign ptr_dec = r_ptr - CW'(1);
    assign tag_inc = CW'(r_tag) + CW'(1);
    assign w_ext   = 64'(i_value_in);
    assign val_ext = 64'(r_val);

    assign o_flags.full        = (r_used == CW'(CAPACITY));
    assign o_flags.empty       = (r_used == '0);
    assign o_flags.idx_lt_used = (r_idx < used_x);
    assign o_flags.idx_lt_cap  = (r_idx < XW'(CAPACITY));
    assign o_flags.ptr_eq_idx  = (ptr_x == r_idx);
    assign o_flags.ptr_eq_used = (r_ptr == r_used);
    assign o_flags.clear_last  = (r_ptr == CW'(CAPACITY - 1));
    assign o_flags.match       = r_pend && (r_rd_data == r_word);
    assign o_flags.scan_miss   = r_pend && (r_rd_data != r_word) && (r_ptr == r_used);

    always_comb begin
        n_used = r_used;
        n_ptr  = r_ptr;
        n_pend = r_pend;
        n_tag  = r_tag;
        n_idx  = r_idx;
        n_word = r_word;
        n_val  = r_val;
        n_pos  = r_pos;
        n_st   = r_st;
        we     = 1'b0;
        waddr  = '0;
        wdata  = '0;
        re     = 1'b0;
        raddr  = '0;
        case (i_op)
            ils_pkg::OP_LOAD: begin
                n_idx  = XW'(i_position_in);
                n_word = w_ext[WORD_BITS-1:0];
                n_val  = '0;
                n_pos  = '0;
                n_st   = ils_pkg::ST_OK;
                n_pend = 1'b0;
            end
            ils_pkg::OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_ptr[AW-1:0];
                n_ptr = ptr_inc;
            end
            ils_pkg::OP_PUSH: begin
                we     = 1'b1;
                waddr  = r_used[AW-1:0];
                wdata  = r_word;
                n_used = r_used + CW'(1);
            end
            ils_pkg::OP_WRITE_AT: begin
                we    = 1'b1;
                waddr = r_idx[AW-1:0];
                wdata = r_word;
                if (!o_flags.idx_lt_used) begin
                    n_used = idx_inc[CW-1:0];
                end
            end
            ils_pkg::OP_READ_AT: begin
                re    = 1'b1;
                raddr = r_idx[AW-1:0];
            end
            ils_pkg::OP_POP: begin
                re     = 1'b1;
                raddr  = used_m1[AW-1:0];
                n_used = used_m1;
            end
            ils_pkg::OP_RM_START: begin
                re     = 1'b1;
                raddr  = r_idx[AW-1:0];
                n_used = used_m1;
                n_ptr  = idx_inc[CW-1:0];
                n_pend = 1'b0;
            end
            ils_pkg::OP_INS_START: begin
                n_used = r_used + CW'(1);
                n_ptr  = used_m1;
                n_pend = 1'b0;
            end
            ils_pkg::OP_CAPTURE: begin
                n_val = r_rd_data;
            end
            ils_pkg::OP_SHIFT_R: begin
                we     = r_pend;
                waddr  = r_tag;
                wdata  = r_rd_data;
                re     = 1'b1;
                raddr  = r_ptr[AW-1:0];
                n_pend = 1'b1;
                n_tag  = ptr_inc[AW-1:0];
                n_ptr  = ptr_dec;
            end
            ils_pkg::OP_SHIFT_L: begin
                we     = r_pend;
                waddr  = r_tag;
                wdata  = r_rd_data;
                re     = 1'b1;
                raddr  = r_ptr[AW-1:0];
                n_pend = 1'b1;
                n_tag  = ptr_dec[AW-1:0];
                n_ptr  = ptr_inc;
            end
            ils_pkg::OP_FLUSH: begin
                we     = r_pend;
                waddr  = r_tag;
                wdata  = r_rd_data;
                n_pend = 1'b0;
            end
            ils_pkg::OP_PLACE: begin
                we    = 1'b1;
                waddr = r_idx[AW-1:0];
                wdata = r_word;
            end
            ils_pkg::OP_SCAN_START: begin
                n_ptr  = '0;
                n_pend = 1'b0;
            end
            ils_pkg::OP_SCAN: begin
                re     = 1'b1;
                raddr  = r_ptr[AW-1:0];
                n_pend = 1'b1;
                n_tag  = r_ptr[AW-1:0];
                n_ptr  = ptr_inc;
            end
            ils_pkg::OP_FOUND: begin
                n_pos = tag_x[3:0];
            end
            ils_pkg::OP_FOUND_RM: begin
                n_pos  = tag_x[3:0];
                n_idx  = tag_x;
                n_ptr  = tag_inc;
                n_used = used_m1;
                n_pend = 1'b0;
            end
            ils_pkg::OP_ERR_EMPTY: begin
                n_st = ils_pkg::ST_EMPTY;
            end
            ils_pkg::OP_ERR_FULL: begin
                n_st = ils_pkg::ST_FULL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ptr  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_used <= n_used;
            r_ptr  <= n_ptr;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_idx  <= n_idx;
        r_word <= n_word;
        r_val  <= n_val;
        r_pos  <= n_pos;
        r_st   <= n_st;
        if (i_op == ils_pkg::OP_FINISH) begin
            r_o_value    <= val_ext[31:0];
            r_o_position <= r_pos;
            r_o_status   <= r_st;
            r_o_count    <= used_x[4:0];
        end
    end

    assign o_value_out    = r_o_value;
    assign o_position_out = r_o_position;
    assign o_status       = r_o_status;
    assign o_count        = r_o_count;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && (i_op == ils_pkg::OP_SHIFT_R || i_op == ils_pkg::OP_SHIFT_L ||
                    i_op == ils_pkg::OP_FLUSH)) |-> (CW'(r_tag) < r_used))
        else $error("shift write outside the list");

    a_error_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == ils_pkg::OP_FINISH && r_st != ils_pkg::ST_OK) |=> (o_value_out == 32'd0))
        else $error("failed request returned a word");

endmodule

FILE: src/ils_ctrl.sv
`timescale 1ns / 1ps

module ils_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_cmd,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  ils_pkg::t_flags i_flags,
    output ils_pkg::t_op    o_op
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_EXEC    = 10'b00_0000_0100,
        S_READ    = 10'b00_0000_1000,
        S_SHIFT_R = 10'b00_0001_0000,
        S_SHIFT_L = 10'b00_0010_0000,
        S_FLUSH   = 10'b00_0100_0000,
        S_PLACE   = 10'b00_1000_0000,
        S_SCAN    = 10'b01_0000_0000,
        S_FINISH  = 10'b10_0000_0000
    } t_state;

    t_state          r_state, n_state;
    ils_pkg::t_cmd   r_cmd, n_cmd;
    logic            r_out_valid, n_out_valid;
    logic            slot_free;
    logic            finish_go;

    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        o_op      = ils_pkg::OP_NOP;
        finish_go = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_op = ils_pkg::OP_CLEAR;
                if (i_flags.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = ils_pkg::OP_LOAD;
                    n_cmd   = ils_pkg::t_cmd'(i_cmd);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FINISH;
                case (r_cmd)
                    ils_pkg::CMD_PUSH: begin
                        o_op = i_flags.full ? ils_pkg::OP_ERR_FULL : ils_pkg::OP_PUSH;
                    end
                    ils_pkg::CMD_POP: begin
                        if (i_flags.empty) begin
                            o_op = ils_pkg::OP_ERR_EMPTY;
                        end else begin
                            o_op    = ils_pkg::OP_POP;
                            n_state = S_READ;
                        end
                    end
                    ils_pkg::CMD_INSERT: begin
                        if (i_flags.idx_lt_used) begin
                            if (i_flags.full) begin
                                o_op = ils_pkg::OP_ERR_FULL;
                            end else begin
                                o_op    = ils_pkg::OP_INS_START;
                                n_state = S_SHIFT_R;
                            end
                        end else if (i_flags.idx_lt_cap) begin
                            o_op = ils_pkg::OP_WRITE_AT;
                        end else begin
                            o_op = ils_pkg::OP_ERR_FULL;
                        end
                    end
                    ils_pkg::CMD_REMOVE: begin
                        if (i_flags.idx_lt_used) begin
                            o_op    = ils_pkg::OP_RM_START;
                            n_state = S_READ;
                        end else begin
                            o_op = ils_pkg::OP_ERR_EMPTY;
                        end
                    end
                    ils_pkg::CMD_GET: begin
                        if (i_flags.idx_lt_used) begin
                            o_op    = ils_pkg::OP_READ_AT;
                            n_state = S_READ;
                        end else begin
                            o_op = ils_pkg::OP_ERR_EMPTY;
                        end
                    end
                    ils_pkg::CMD_PUT: begin
                        if (i_flags.idx_lt_used || i_flags.idx_lt_cap) begin
                            o_op = ils_pkg::OP_WRITE_AT;
                        end else begin
                            o_op = ils_pkg::OP_ERR_FULL;
                        end
                    end
                    default: begin
                        if (i_flags.empty) begin
                            o_op = ils_pkg::OP_ERR_EMPTY;
                        end else begin
                            o_op    = ils_pkg::OP_SCAN_START;
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_READ: begin
                o_op    = ils_pkg::OP_CAPTURE;
                n_state = S_FINISH;
                if ((r_cmd inside {ils_pkg::CMD_REMOVE, ils_pkg::CMD_REMOVE_VAL}) &&
                    i_flags.idx_lt_used) begin
                    n_state = S_SHIFT_L;
                end
            end
            S_SHIFT_R: begin
                o_op = ils_pkg::OP_SHIFT_R;
                if (i_flags.ptr_eq_idx) begin
                    n_state = S_FLUSH;
                end
            end
            S_SHIFT_L: begin
                o_op = ils_pkg::OP_SHIFT_L;
                if (i_flags.ptr_eq_used) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_op    = ils_pkg::OP_FLUSH;
                n_state = (r_cmd == ils_pkg::CMD_INSERT) ? S_PLACE : S_FINISH;
            end
            S_PLACE: begin
                o_op    = ils_pkg::OP_PLACE;
                n_state = S_FINISH;
            end
            S_SCAN: begin
                if (i_flags.match) begin
                    if (r_cmd == ils_pkg::CMD_FIND) begin
                        o_op    = ils_pkg::OP_FOUND;
                        n_state = S_FINISH;
                    end else begin
                        o_op    = ils_pkg::OP_FOUND_RM;
                        n_state = S_READ;
                    end
                end else if (i_flags.scan_miss) begin
                    o_op    = ils_pkg::OP_ERR_EMPTY;
                    n_state = S_FINISH;
                end else begin
                    o_op = ils_pkg::OP_SCAN;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_op      = ils_pkg::OP_FINISH;
                    finish_go = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = finish_go ? 1'b1 : (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside the finish step");

endmodule

FILE: src/indexed_list_store_core.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words with push, pop, insert, remove at
// index, get, put, find and remove first match.
// Request channel: i_valid / o_stall with i_cmd, i_position_in, i_value_in.
// Result channel: o_valid / i_stall with o_value_out, o_position_out,
// o_status and o_count. Each request gives exactly one result.
// Insert inside the list shifts the entries from the index onward one place
// up, remove at index shifts the entries behind the index one place down,
// find scans from the head of the list, and remove value scans and then
// shifts like remove. The next request is taken in idle once the current
// result has gone to the output register. The list store is a
// single memory with one write and one registered read port, so every
// shift step moves and every search step reads one entry per cycle.
// After reset the store is cleared one entry per cycle while o_stall
// stays high; the length reads zero.
// A finished result waits in an output register while i_stall is high;
// the next request is still accepted and processed, and its result is
// held back until the output register is free.
module indexed_list_store_core #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_position_in,
    input  logic [31:0] i_value_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value_out,
    output logic [3:0]  o_position_out,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count
);

    ils_pkg::t_op    op;
    ils_pkg::t_flags flags;

    ils_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_flags (flags),
        .o_op    (op)
    );

    ils_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_position_in  (i_position_in),
        .i_value_in     (i_value_in),
        .o_flags        (flags),
        .o_value_out    (o_value_out),
        .o_position_out (o_position_out),
        .o_status       (o_status),
        .o_count        (o_count)
    );

endmodule
